// ===== rtl/rgbds_pkg.sv =====
// Shared types and constants of the RGB565 nearest-neighbor downscaler.
package rgbds_pkg;

  localparam int CFG_W = 12;
  localparam int IDX_W = 3;
  localparam int PIX_W = 16;
  localparam int VAL_W = 8;
  localparam int CH_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3,
    REG_GRAY_MODE  = 3'd4
  } cfg_idx_e;

  localparam logic [CH_W-1:0] CH_RED_GRAY = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN    = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE     = 2'd2;

  localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 12'd320;
  localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 12'd240;
  localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 12'd96;
  localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 12'd96;

  // Reciprocal of 3 in 11 fractional bits; exact floor for sums below 2048.
  localparam logic [9:0] RECIP3     = 10'd683;
  localparam int         RECIP3_SHR = 11;

  typedef struct packed {
    logic [CFG_W-1:0] src_width;
    logic [CFG_W-1:0] src_height;
    logic [CFG_W-1:0] out_width;
    logic [CFG_W-1:0] out_height;
    logic             gray_mode;
  } cfg_t;

  typedef struct packed {
    logic keep;
    logic last_frame;
  } pick_t;

endpackage

// ===== rtl/rgbds_if.sv =====
// Valid/ready channel interfaces for configuration, pixels and results.
interface rgbds_cfg_if;
  import rgbds_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface rgbds_pix_if;
  import rgbds_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, pixel, input ready);
  modport sink   (input valid, pixel, output ready);
endinterface

interface rgbds_res_if;
  import rgbds_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic [CH_W-1:0]         channel;
  logic                    last_of_pixel;
  logic                    last_of_frame;
  modport source (output valid, value, channel, last_of_pixel, last_of_frame, input ready);
  modport sink   (input valid, value, channel, last_of_pixel, last_of_frame, output ready);
endinterface

// ===== rtl/rgbds_sel.sv =====
// Raster position counters and the nearest-neighbor pick test.
module rgbds_sel #(
  parameter int COORD_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rgbds_pkg::cfg_t cfg_i,
  input  logic           step_i,
  output rgbds_pkg::pick_t pick_o
);
  import rgbds_pkg::*;

  localparam int C = COORD_BITS;
  localparam int S = 2 * COORD_BITS;

  logic [15:0]  sw_x, sh_x, ow_x, oh_x;
  logic [C-1:0] sw_m, sh_m, ow_m, oh_m;
  logic [C-1:0] sw, sh, ow1, oh1, ow, oh;

  logic [C-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [C-1:0] out_col_q, out_col_d, out_row_q, out_row_d;
  logic [S-1:0] col_tgt_q, col_tgt_d, col_base_q, col_base_d;
  logic [S-1:0] row_tgt_q, row_tgt_d, row_base_q, row_base_d;

  logic         col_hit, row_hit, col_wrap, row_wrap;
  logic [C-1:0] col_inc, row_inc;

  // Size registers are narrowed to the coordinate width; zero acts as one.
  assign sw_x = 16'(cfg_i.src_width);
  assign sh_x = 16'(cfg_i.src_height);
  assign ow_x = 16'(cfg_i.out_width);
  assign oh_x = 16'(cfg_i.out_height);
  assign sw_m = sw_x[C-1:0];
  assign sh_m = sh_x[C-1:0];
  assign ow_m = ow_x[C-1:0];
  assign oh_m = oh_x[C-1:0];
  assign sw   = (sw_m == '0) ? C'(1) : sw_m;
  assign sh   = (sh_m == '0) ? C'(1) : sh_m;
  assign ow1  = (ow_m == '0) ? C'(1) : ow_m;
  assign oh1  = (oh_m == '0) ? C'(1) : oh_m;
  assign ow   = (ow1 > sw) ? sw : ow1;
  assign oh   = (oh1 > sh) ? sh : oh1;

  assign col_hit = (out_col_q < ow) && (col_base_q <= col_tgt_q) &&
                   ({1'b0, col_tgt_q} < ({1'b0, col_base_q} + (S+1)'(ow)));
  assign row_hit = (out_row_q < oh) && (row_base_q <= row_tgt_q) &&
                   ({1'b0, row_tgt_q} < ({1'b0, row_base_q} + (S+1)'(oh)));

  assign col_inc  = src_col_q + C'(1);
  assign row_inc  = src_row_q + C'(1);
  assign col_wrap = (col_inc == '0) || (col_inc >= sw);
  assign row_wrap = (row_inc == '0) || (row_inc >= sh);

  assign pick_o.keep       = col_hit && row_hit;
  assign pick_o.last_frame = (({1'b0, out_col_q} + (C+1)'(1)) == {1'b0, ow}) &&
                             (({1'b0, out_row_q} + (C+1)'(1)) == {1'b0, oh});

  always_comb begin
    src_col_d  = src_col_q;
    src_row_d  = src_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    col_tgt_d  = col_tgt_q;
    col_base_d = col_base_q;
    row_tgt_d  = row_tgt_q;
    row_base_d = row_base_q;
    if (step_i) begin
      if (col_hit) begin
        out_col_d = out_col_q + C'(1);
        col_tgt_d = col_tgt_q + S'(sw);
      end
      col_base_d = col_base_q + S'(ow);
      src_col_d  = col_inc;
      // End of source row: restart columns and advance the row tracking.
      if (col_wrap) begin
        src_col_d  = '0;
        out_col_d  = '0;
        col_tgt_d  = '0;
        col_base_d = '0;
        if (row_hit) begin
          out_row_d = out_row_q + C'(1);
          row_tgt_d = row_tgt_q + S'(sh);
        end
        row_base_d = row_base_q + S'(oh);
        src_row_d  = row_inc;
        if (row_wrap) begin
          src_row_d  = '0;
          out_row_d  = '0;
          row_tgt_d  = '0;
          row_base_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q  <= '0;
      src_row_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      col_tgt_q  <= '0;
      col_base_q <= '0;
      row_tgt_q  <= '0;
      row_base_q <= '0;
    end else begin
      src_col_q  <= src_col_d;
      src_row_q  <= src_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      col_tgt_q  <= col_tgt_d;
      col_base_q <= col_base_d;
      row_tgt_q  <= row_tgt_d;
      row_base_q <= row_base_d;
    end
  end

endmodule

// ===== rtl/rgbds_emit.sv =====
// Result register: holds a kept pixel and emits its gray or color values.
module rgbds_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [rgbds_pkg::PIX_W-1:0] pixel_i,
  input  logic                        gray_i,
  input  logic                        last_frame_i,
  output logic                        ready_o,
  rgbds_res_if.source                 res_o
);
  import rgbds_pkg::*;

  logic             valid_q, valid_d;
  logic [PIX_W-1:0] px_q;
  logic             gray_q;
  logic             lf_q;
  logic [CH_W-1:0]  idx_q, idx_d;

  logic [7:0]  r8, g8, b8, sel8, gray8;
  logic [9:0]  sum;
  logic [19:0] prod;
  logic        last_pix;
  logic        done;

  assign r8   = {px_q[15:11], 3'b000};
  assign g8   = {px_q[10:5], 2'b00};
  assign b8   = {px_q[4:0], 3'b000};
  assign sum  = 10'(r8) + 10'(g8) + 10'(b8);
  assign prod = 20'(sum) * 20'(RECIP3);
  assign gray8 = prod[RECIP3_SHR +: 8];

  always_comb begin
    case (idx_q)
      CH_GREEN: sel8 = g8;
      CH_BLUE:  sel8 = b8;
      default:  sel8 = r8;
    endcase
    if (gray_q) begin
      sel8 = gray8;
    end
  end

  assign last_pix = gray_q || (idx_q == CH_BLUE);
  assign done     = res_o.ready && last_pix;
  assign ready_o  = !valid_q || done;

  assign res_o.valid         = valid_q;
  assign res_o.value         = signed'(sel8 ^ 8'h80);
  assign res_o.channel       = gray_q ? CH_RED_GRAY : idx_q;
  assign res_o.last_of_pixel = last_pix;
  assign res_o.last_of_frame = last_pix && lf_q;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (valid_q && res_o.ready) begin
      if (last_pix) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + CH_W'(1);
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = CH_RED_GRAY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= CH_RED_GRAY;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      px_q   <= pixel_i;
      gray_q <= gray_i;
      lf_q   <= last_frame_i;
    end
  end

endmodule

// ===== rtl/rgb565_nearest_downscale_int8_core.sv =====
// Top level of the RGB565 nearest-neighbor downscaler with signed 8-bit output.
// A kept pixel shows its first value in the cycle after its transaction.
// Throughput: one pixel per cycle while the result register can take it; a kept
// pixel holds it until its last value is taken, dropped pixels pass at once.
// Reset: sizes go to 320x240 -> 96x96 in gray mode, all position counters to zero.
module rgb565_nearest_downscale_int8_core #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgbds_cfg_if.sink   cfg_i,
  rgbds_pix_if.sink   pix_i,
  rgbds_res_if.source res_o
);
  import rgbds_pkg::*;

  cfg_t  cfg_q, cfg_d;
  pick_t pick;
  logic  emit_ready;
  logic  step;
  logic  load;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SRC_WIDTH:  cfg_d.src_width  = cfg_i.data;
        REG_SRC_HEIGHT: cfg_d.src_height = cfg_i.data;
        REG_OUT_WIDTH:  cfg_d.out_width  = cfg_i.data;
        REG_OUT_HEIGHT: cfg_d.out_height = cfg_i.data;
        REG_GRAY_MODE:  cfg_d.gray_mode  = cfg_i.data[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= RST_SRC_WIDTH;
      cfg_q.src_height <= RST_SRC_HEIGHT;
      cfg_q.out_width  <= RST_OUT_WIDTH;
      cfg_q.out_height <= RST_OUT_HEIGHT;
      cfg_q.gray_mode  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Dropped pixels never need the result register.
  assign pix_i.ready = !pick.keep || emit_ready;
  assign step        = pix_i.valid && pix_i.ready;
  assign load        = step && pick.keep;

  rgbds_sel #(
    .COORD_BITS (COORD_BITS)
  ) u_sel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .step_i (step),
    .pick_o (pick)
  );

  rgbds_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .pixel_i      (pix_i.pixel),
    .gray_i       (cfg_q.gray_mode),
    .last_frame_i (pick.last_frame),
    .ready_o      (emit_ready),
    .res_o        (res_o)
  );

endmodule

// ===== rtl/rgbds_chk.sv =====
// Port-level checker for the downscaler core and its bind statement.
module rgbds_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_ready_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic [rgbds_pkg::CH_W-1:0] res_channel_i,
  input logic                       res_lp_i,
  input logic                       res_lf_i
);
  import rgbds_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port not ready");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_lf_i |-> res_lp_i)
    else $error("frame end not on last value of a pixel");

  a_chan_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && !res_lp_i |=>
      res_valid_i && (res_channel_i == $past(res_channel_i) + CH_W'(1)))
    else $error("color values out of sequence");

  a_blue_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_channel_i == CH_BLUE) |-> res_lp_i)
    else $error("blue value not marked last of pixel");

endmodule

bind rgb565_nearest_downscale_int8_core rgbds_chk u_rgbds_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_ready_i   (cfg_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_channel_i (res_o.channel),
  .res_lp_i      (res_o.last_of_pixel),
  .res_lf_i      (res_o.last_of_frame)
);
